/* hdl/ihl_pkg.sv */
// Shared types and constants for the hex image loader.
`timescale 1ns / 1ps
package ihl_pkg;

   localparam int IMAGE_WORDS = 16384;
   localparam int IMG_AW      = $clog2(IMAGE_WORDS);
   localparam int REC_MAX     = 255;
   localparam int BYTE_LIMIT  = 2 * IMAGE_WORDS;

   localparam logic [7:0] KIND_DATA = 8'h00;
   localparam logic [7:0] KIND_EOF  = 8'h01;

   typedef enum logic [1:0] {
      OP_CHAR = 2'd0,
      OP_END  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // classified request as it travels from front to back
   typedef struct packed {
      op_type      op;
      logic [13:0] word_addr;
      logic        is_ws;
      logic        is_colon;
      logic        is_hex;
      logic [3:0]  digit;
   } item_type;

endpackage

/* hdl/ihl_front.sv */
// Front end: takes requests and classifies the text character.
`timescale 1ns / 1ps
module ihl_front import ihl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_text_char,
   input  logic [13:0] req_word_addr,
   input  logic        q_full,
   input  logic        init_done,
   output logic        q_push,
   output item_type    q_item
);

   logic       busy_ff, busy_in;
   logic [7:0] c;

   // hold off requests from reset until memory is cleared and the registered busy flag drops
   assign busy_in = ~init_done;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign req_ready = ~q_full & ~busy_ff & init_done;
   assign q_push    = req_valid & req_ready;
   assign c         = req_text_char;

   always_comb begin
      q_item.op        = op_type'(req_op);
      q_item.word_addr = req_word_addr;
      q_item.is_ws     = (c == 8'h0d) || (c == 8'h0a) || (c == 8'h20) || (c == 8'h09);
      q_item.is_colon  = (c == 8'h3a);
      q_item.is_hex    = 1'b0;
      q_item.digit     = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         q_item.is_hex = 1'b1;
         q_item.digit  = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         q_item.is_hex = 1'b1;
         q_item.digit  = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         q_item.is_hex = 1'b1;
         q_item.digit  = 4'(c - 8'h57);
      end
   end

endmodule

/* hdl/ihl_queue.sv */
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module ihl_queue import ihl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     avail,
   output item_type head
);

   item_type   ent_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign avail = (cnt_ff != 2'd0);
   assign head  = ent_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_item;
      end
   end

endmodule

/* hdl/ihl_back.sv */
// Back end: record parser, image memories, copy sweeps and result register.
`timescale 1ns / 1ps
module ihl_back import ihl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_avail,
   input  item_type    q_head,
   output logic        q_pop,
   output logic        init_done,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_word,
   output logic        rsp_load_done,
   output logic        rsp_load_ok,
   output logic        rsp_error_seen
);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_LOAD   = 8'b0000_0100,
      S_CHAR   = 8'b0000_1000,
      S_WRITE  = 8'b0001_0000,
      S_COMMIT = 8'b0010_0000,
      S_READ   = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   typedef enum logic [6:0] {
      P_IDLE    = 7'b000_0001,
      P_COUNT   = 7'b000_0010,
      P_ADDR_HI = 7'b000_0100,
      P_ADDR_LO = 7'b000_1000,
      P_KIND    = 7'b001_0000,
      P_DATA    = 7'b010_0000,
      P_CSUM    = 7'b100_0000
   } phase_type;

   state_type   st_ff, st_in;
   phase_type   phase_ff, phase_in;
   item_type    cur_ff, cur_in;
   logic        half_ff, half_in;
   logic [3:0]  hold_ff, hold_in;
   logic [7:0]  seen_ff, seen_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  sum_ff, sum_in;
   logic        end_ff, end_in;
   logic        failed_ff, failed_in;
   logic        active_ff, active_in;
   logic        ok_ff, ok_in;
   logic [IMG_AW:0]   cnt_ff, cnt_in;
   logic [7:0]        bcnt_ff, bcnt_in;
   logic              pvld_ff, pvld_in;
   logic [IMG_AW-1:0] pwa_ff, pwa_in;
   logic              plane_ff, plane_in;
   logic        rv_ff, rv_in;
   logic [15:0] rword_ff, rword_in;
   logic        rdone_ff, rdone_in, rok_ff, rok_in, rerr_ff, rerr_in;

   // memories
   logic [15:0] cmem [IMAGE_WORDS];
   logic [7:0]  smem_lo [IMAGE_WORDS];
   logic [7:0]  smem_hi [IMAGE_WORDS];
   logic [7:0]  rbuf [REC_MAX];
   logic [15:0] cmem_rd_ff;
   logic [7:0]  slo_rd_ff, shi_rd_ff, rb_rd_ff;

   logic              cmem_we;
   logic [IMG_AW-1:0] cmem_wa, cmem_ra;
   logic [15:0]       cmem_wd;
   logic              slo_we, shi_we;
   logic [IMG_AW-1:0] smem_wa;
   logic [7:0]        slo_wd, shi_wd;
   logic              rb_we;
   logic [7:0]        rb_wa, rb_wd;

   logic [7:0]  byte_val;
   logic [16:0] ba;
   logic [15:0] wa_ext;
   logic        in_range, go_ok;

   assign wa_ext    = 16'(cur_ff.word_addr);
   assign in_range  = (32'(cur_ff.word_addr) < IMAGE_WORDS);
   assign byte_val  = {hold_ff, cur_ff.digit};
   assign ba        = {1'b0, addr_ff} + 17'(bcnt_ff);
   assign init_done = (st_ff != S_CLEAR);
   assign go_ok     = active_ff & ~failed_ff & end_ff & (phase_ff == P_IDLE);

   assign rsp_valid      = rv_ff;
   assign rsp_read_word  = rword_ff;
   assign rsp_load_done  = rdone_ff;
   assign rsp_load_ok    = rok_ff;
   assign rsp_error_seen = rerr_ff;

   always_comb begin
      st_in = st_ff;  phase_in = phase_ff;  cur_in = cur_ff;
      half_in = half_ff;  hold_in = hold_ff;  seen_in = seen_ff;
      len_in = len_ff;  addr_in = addr_ff;  kind_in = kind_ff;  sum_in = sum_ff;
      end_in = end_ff;  failed_in = failed_ff;  active_in = active_ff;  ok_in = ok_ff;
      cnt_in = cnt_ff;  bcnt_in = bcnt_ff;
      pvld_in = 1'b0;  pwa_in = pwa_ff;  plane_in = plane_ff;
      rv_in = rv_ff & ~rsp_ready;
      rword_in = rword_ff;  rdone_in = rdone_ff;  rok_in = rok_ff;  rerr_in = rerr_ff;
      q_pop = 1'b0;
      cmem_we = 1'b0;  cmem_wa = pwa_ff;  cmem_wd = {shi_rd_ff, slo_rd_ff};
      cmem_ra = (st_ff == S_LOAD) ? cnt_ff[IMG_AW-1:0] : wa_ext[IMG_AW-1:0];
      slo_we = 1'b0;  shi_we = 1'b0;  smem_wa = pwa_ff;
      slo_wd = cmem_rd_ff[7:0];  shi_wd = cmem_rd_ff[15:8];
      rb_we = 1'b0;  rb_wa = seen_ff;  rb_wd = byte_val;

      unique case (st_ff)
         S_CLEAR: begin
            cmem_we = 1'b1;
            cmem_wa = cnt_ff[IMG_AW-1:0];
            cmem_wd = 16'd0;
            cnt_in  = cnt_ff + (IMG_AW+1)'(1);
            if (cnt_ff == (IMG_AW+1)'(IMAGE_WORDS - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_avail) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               unique case (q_head.op)
                  OP_CHAR: begin
                     if (active_ff) begin
                        st_in = S_CHAR;
                     end else begin
                        phase_in = P_IDLE;  half_in = 1'b0;  hold_in = 4'd0;
                        seen_in = 8'd0;  len_in = 8'd0;  addr_in = 16'd0;
                        kind_in = 8'd0;  sum_in = 8'd0;
                        end_in = 1'b0;  failed_in = 1'b0;  active_in = 1'b1;
                        cnt_in = '0;
                        st_in = S_LOAD;
                     end
                  end
                  OP_END: begin
                     ok_in = go_ok;
                     phase_in = P_IDLE;  half_in = 1'b0;  hold_in = 4'd0;
                     seen_in = 8'd0;  len_in = 8'd0;  addr_in = 16'd0;
                     kind_in = 8'd0;  sum_in = 8'd0;
                     end_in = 1'b0;  failed_in = 1'b0;  active_in = 1'b0;
                     cnt_in = '0;
                     st_in = go_ok ? S_COMMIT : S_RESP;
                  end
                  OP_READ: st_in = S_READ;
                  default: st_in = S_RESP;
               endcase
            end
         end
         S_LOAD: begin
            // committed -> staged, one word a cycle; the write takes the registered read word
            if (cnt_ff != (IMG_AW+1)'(IMAGE_WORDS)) begin
               pvld_in = 1'b1;
               pwa_in  = cnt_ff[IMG_AW-1:0];
               cnt_in  = cnt_ff + (IMG_AW+1)'(1);
            end
            slo_we = pvld_ff;
            shi_we = pvld_ff;
            if (cnt_ff == (IMG_AW+1)'(IMAGE_WORDS) && !pvld_ff) begin
               st_in = S_CHAR;
            end
         end
         S_CHAR: begin
            st_in = S_RESP;
            if (failed_ff) begin
               // ignore text after an error
            end else if (phase_ff == P_IDLE) begin
               if (!cur_ff.is_ws) begin
                  if (end_ff || !cur_ff.is_colon) begin
                     failed_in = 1'b1;
                  end else begin
                     half_in = 1'b0;  hold_in = 4'd0;  seen_in = 8'd0;
                     len_in = 8'd0;  addr_in = 16'd0;  kind_in = 8'd0;
                     sum_in = 8'd0;
                     phase_in = P_COUNT;
                  end
               end
            end else if (!cur_ff.is_hex) begin
               failed_in = 1'b1;
            end else if (!half_ff) begin
               hold_in = cur_ff.digit;
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               sum_in  = sum_ff + byte_val;
               unique case (phase_ff)
                  P_COUNT: begin
                     len_in = byte_val;  phase_in = P_ADDR_HI;
                  end
                  P_ADDR_HI: begin
                     addr_in = {byte_val, 8'd0};  phase_in = P_ADDR_LO;
                  end
                  P_ADDR_LO: begin
                     addr_in = addr_ff | 16'(byte_val);  phase_in = P_KIND;
                  end
                  P_KIND: begin
                     kind_in  = byte_val;
                     seen_in  = 8'd0;
                     phase_in = (len_ff == 8'd0) ? P_CSUM : P_DATA;
                  end
                  P_DATA: begin
                     rb_we   = (32'(seen_ff) < REC_MAX);
                     seen_in = seen_ff + 8'd1;
                     if (seen_ff + 8'd1 >= len_ff) begin
                        phase_in = P_CSUM;
                     end
                  end
                  default: begin
                     sum_in   = sum_ff;
                     phase_in = P_IDLE;
                     if (8'(sum_ff + byte_val) != 8'd0) begin
                        failed_in = 1'b1;
                     end else if (kind_ff == KIND_EOF) begin
                        end_in = 1'b1;
                     end else if (kind_ff != KIND_DATA) begin
                        failed_in = 1'b1;
                     end else if (len_ff != 8'd0) begin
                        bcnt_in = 8'd0;
                        st_in   = S_WRITE;
                     end
                  end
               endcase
            end
         end
         S_WRITE: begin
            // record bytes -> staged image, one byte lane per cycle
            if (bcnt_ff != len_ff && !failed_ff) begin
               if (ba >= 17'(BYTE_LIMIT)) begin
                  failed_in = 1'b1;
               end else begin
                  pvld_in  = 1'b1;
                  pwa_in   = ba[IMG_AW:1];
                  plane_in = ba[0];
                  bcnt_in  = bcnt_ff + 8'd1;
               end
            end
            slo_we = pvld_ff & ~plane_ff;
            shi_we = pvld_ff & plane_ff;
            slo_wd = rb_rd_ff;
            shi_wd = rb_rd_ff;
            if ((bcnt_ff == len_ff || failed_ff) && !pvld_ff) begin
               st_in = S_RESP;
            end
         end
         S_COMMIT: begin
            // staged -> committed
            if (cnt_ff != (IMG_AW+1)'(IMAGE_WORDS)) begin
               pvld_in = 1'b1;
               pwa_in  = cnt_ff[IMG_AW-1:0];
               cnt_in  = cnt_ff + (IMG_AW+1)'(1);
            end
            cmem_we = pvld_ff;
            if (cnt_ff == (IMG_AW+1)'(IMAGE_WORDS) && !pvld_ff) begin
               st_in = S_RESP;
            end
         end
         S_READ: st_in = S_RESP;
         default: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rword_in = (cur_ff.op == OP_READ && in_range) ? cmem_rd_ff : 16'd0;
               rdone_in = (cur_ff.op == OP_END);
               rok_in   = (cur_ff.op == OP_END) & ok_ff;
               if (cur_ff.op == OP_CHAR) begin
                  rerr_in = failed_ff;
               end else if (cur_ff.op == OP_END) begin
                  rerr_in = ~ok_ff;
               end else begin
                  rerr_in = active_ff & failed_ff;
               end
               st_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;  phase_ff <= P_IDLE;  half_ff <= 1'b0;  hold_ff <= 4'd0;
         seen_ff <= 8'd0;  len_ff <= 8'd0;  addr_ff <= 16'd0;  kind_ff <= 8'd0;
         sum_ff <= 8'd0;  end_ff <= 1'b0;  failed_ff <= 1'b0;  active_ff <= 1'b0;
         cnt_ff <= '0;  bcnt_ff <= 8'd0;  pvld_ff <= 1'b0;  rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;  phase_ff <= phase_in;  half_ff <= half_in;  hold_ff <= hold_in;
         seen_ff <= seen_in;  len_ff <= len_in;  addr_ff <= addr_in;  kind_ff <= kind_in;
         sum_ff <= sum_in;  end_ff <= end_in;  failed_ff <= failed_in;
         active_ff <= active_in;  cnt_ff <= cnt_in;  bcnt_ff <= bcnt_in;
         pvld_ff <= pvld_in;  rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;  ok_ff <= ok_in;  pwa_ff <= pwa_in;  plane_ff <= plane_in;
      rword_ff <= rword_in;  rdone_ff <= rdone_in;  rok_ff <= rok_in;  rerr_ff <= rerr_in;
   end

   always_ff @(posedge clock) begin
      if (cmem_we) begin
         cmem[cmem_wa] <= cmem_wd;
      end
      cmem_rd_ff <= cmem[cmem_ra];
   end

   always_ff @(posedge clock) begin
      if (slo_we) begin
         smem_lo[smem_wa] <= slo_wd;
      end
      if (shi_we) begin
         smem_hi[smem_wa] <= shi_wd;
      end
      slo_rd_ff <= smem_lo[cnt_ff[IMG_AW-1:0]];
      shi_rd_ff <= smem_hi[cnt_ff[IMG_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (rb_we) begin
         rbuf[rb_wa] <= rb_wd;
      end
      rb_rd_ff <= rbuf[bcnt_ff];
   end

endmodule

/* hdl/intel_hex_image_loader.sv */
// Top level of the Intel HEX image loader.
`timescale 1ns / 1ps
// Intel HEX text comes in one character per request (op 0); op 1 ends the
// text and commits the staged 16-bit word image if the load was clean, and
// op 2 reads a committed word. Each request gives exactly one response. A
// front stage classifies characters into a two-entry queue; the back end
// parses records and owns the memories. The first character of a load
// first copies the committed image into the staging memory. The checksum
// character of a data record writes its bytes one per cycle. A successful
// end of text copies staging back. After reset the committed image is
// cleared word by word, and no request is taken meanwhile.
module intel_hex_image_loader import ihl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_text_char,
   input  logic [13:0] req_word_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_word,
   output logic        rsp_load_done,
   output logic        rsp_load_ok,
   output logic        rsp_error_seen
);

   logic     q_full, q_push, q_pop, q_avail, init_done;
   item_type q_item, q_head;

   ihl_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_text_char,
      .req_word_addr, .q_full, .init_done, .q_push, .q_item
   );

   ihl_queue u_queue (
      .clock, .reset, .push(q_push), .push_item(q_item), .full(q_full),
      .pop(q_pop), .avail(q_avail), .head(q_head)
   );

   ihl_back u_back (
      .clock, .reset, .q_avail, .q_head, .q_pop, .init_done,
      .rsp_valid, .rsp_ready, .rsp_read_word, .rsp_load_done,
      .rsp_load_ok, .rsp_error_seen
   );

endmodule

/* tb/ihl_checker.sv */
// Response predictor and checker for the hex image loader.
`timescale 1ns / 1ps
module ihl_checker import ihl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_text_char,
   input  logic [13:0] req_word_addr,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_read_word,
   input  logic        rsp_load_done,
   input  logic        rsp_load_ok,
   input  logic        rsp_error_seen,
   output int          fail_count,
   output int          pending
);

   typedef enum logic [2:0] {
      P_IDLE, P_COUNT, P_ADDR_HI, P_ADDR_LO, P_KIND, P_DATA, P_CSUM
   } phase_type;

   typedef struct packed {
      logic [15:0] read_word;
      logic        load_done;
      logic        load_ok;
      logic        error_seen;
   } rsp_type;

   phase_type   phase;
   logic        half_pending;
   logic [3:0]  high_nib;
   logic [7:0]  bytes_seen, rec_len, rec_kind, sum;
   logic [15:0] rec_addr;
   logic [7:0]  rec_buf [REC_MAX];
   logic [15:0] staged_img [IMAGE_WORDS];
   logic [15:0] committed_img [IMAGE_WORDS];
   logic        eof_seen, failed, active;
   rsp_type     expected_q [$];

   assign pending = expected_q.size();

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   task automatic clear_record();
      phase = P_IDLE;
      half_pending = 1'b0;
      high_nib = '0;
      bytes_seen = '0;
      rec_len = '0;
      rec_addr = '0;
      rec_kind = '0;
      sum = '0;
   endtask

   task automatic close_record(input logic [7:0] csum);
      int ba;
      phase = P_IDLE;
      if (8'(sum + csum) != 8'h00) begin
         failed = 1'b1;
         return;
      end
      if (rec_kind == KIND_EOF) begin
         eof_seen = 1'b1;
         return;
      end
      if (rec_kind != KIND_DATA) begin
         failed = 1'b1;
         return;
      end
      for (int i = 0; i < rec_len; i++) begin
         ba = rec_addr + i;
         if (ba >= BYTE_LIMIT) begin
            failed = 1'b1;
            return;
         end
         if (ba[0]) staged_img[ba >> 1][15:8] = rec_buf[i];
         else       staged_img[ba >> 1][7:0]  = rec_buf[i];
      end
   endtask

   task automatic take_byte(input logic [7:0] b);
      case (phase)
         P_COUNT: begin
            sum = sum + b; rec_len = b; phase = P_ADDR_HI;
         end
         P_ADDR_HI: begin
            sum = sum + b; rec_addr = {b, 8'h00}; phase = P_ADDR_LO;
         end
         P_ADDR_LO: begin
            sum = sum + b; rec_addr[7:0] = b; phase = P_KIND;
         end
         P_KIND: begin
            sum = sum + b; rec_kind = b; bytes_seen = '0;
            phase = (rec_len == 0) ? P_CSUM : P_DATA;
         end
         P_DATA: begin
            sum = sum + b;
            if (bytes_seen < REC_MAX) rec_buf[bytes_seen] = b;
            bytes_seen = bytes_seen + 8'd1;
            if (bytes_seen >= rec_len) phase = P_CSUM;
         end
         default: close_record(b);
      endcase
   endtask

   task automatic take_char(input logic [7:0] c);
      int d;
      if (!active) begin
         staged_img = committed_img;
         clear_record();
         eof_seen = 1'b0;
         failed = 1'b0;
         active = 1'b1;
      end
      if (failed) return;
      if (phase == P_IDLE) begin
         if (c == 8'h0d || c == 8'h0a || c == " " || c == 8'h09) return;
         if (eof_seen || c != ":") begin
            failed = 1'b1;
            return;
         end
         clear_record();
         phase = P_COUNT;
         return;
      end
      d = hex_value(c);
      if (d < 0) begin
         failed = 1'b1;
         return;
      end
      if (!half_pending) begin
         high_nib = d[3:0];
         half_pending = 1'b1;
         return;
      end
      half_pending = 1'b0;
      take_byte({high_nib, d[3:0]});
   endtask

   task automatic predict(input op_type op, input logic [7:0] c, input logic [13:0] wa);
      rsp_type e;
      logic ok;
      e = '0;
      case (op)
         OP_CHAR: begin
            take_char(c);
            e.error_seen = failed;
         end
         OP_END: begin
            ok = active && !failed && eof_seen && phase == P_IDLE;
            if (ok) committed_img = staged_img;
            e.load_done = 1'b1;
            e.load_ok = ok;
            e.error_seen = !ok;
            clear_record();
            eof_seen = 1'b0;
            failed = 1'b0;
            active = 1'b0;
         end
         default: begin
            if (op == OP_READ) e.read_word = committed_img[wa];
            e.error_seen = active && failed;
         end
      endcase
      expected_q.push_back(e);
   endtask

   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         clear_record();
         foreach (committed_img[i]) committed_img[i] = '0;
         eof_seen = 1'b0;
         failed = 1'b0;
         active = 1'b0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready)
            predict(op_type'(req_op), req_text_char, req_word_addr);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_read_word, rsp_load_done, rsp_load_ok, rsp_error_seen};
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response %h", $realtime, got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: word %h/%h done %b/%b ok %b/%b err %b/%b (exp/act)",
                        $realtime, want.read_word, got.read_word, want.load_done,
                        got.load_done, want.load_ok, got.load_ok, want.error_seen,
                        got.error_seen);
               end
            end
         end
      end
   end

endmodule

/* tb/intel_hex_image_loader_tb.sv */
// Stimulus and verdict for the hex image loader.
`timescale 1ns / 1ps
module intel_hex_image_loader_tb;
   import ihl_pkg::*;

   // ways a record can be spoiled
   localparam int FL_NONE    = 0;
   localparam int FL_CSUM    = 1;
   localparam int FL_BADCHAR = 2;
   localparam int FL_SPACE   = 3;
   localparam int FL_TRUNC   = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_NONE;
   logic [7:0]  req_text_char = '0;
   logic [13:0] req_word_addr = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_read_word;
   logic        rsp_load_done, rsp_load_ok, rsp_error_seen;
   int          fail_count, pending;
   int          sent = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_cnt = 0;

   intel_hex_image_loader dut (.*);
   ihl_checker chk (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver: draws its stall style at random -- always ready,
   // coin flip, or long stalls with short windows.
   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // One request. The sender runs in bursts; between bursts valid drops
   // so gaps land at every point of the back end's work.
   task automatic send(input op_type op, input logic [7:0] c, input logic [13:0] wa);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_text_char <= c;
      req_word_addr <= wa;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      sent++;
   endtask

   task automatic put_char(input logic [7:0] c);
      // now and then a read or an unused op lands inside the text
      if ($urandom_range(0, 24) == 0)
         send($urandom_range(0, 1) ? OP_READ : OP_NONE, 8'($urandom), 14'($urandom));
      send(OP_CHAR, c, 14'($urandom));
   endtask

   function automatic logic [7:0] nib_char(input logic [3:0] n);
      if (n < 10) return "0" + n;
      return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom);
      while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
      return c;
   endfunction

   task automatic put_space();
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 3))
            0: put_char(8'h0d);
            1: put_char(8'h0a);
            2: put_char(" ");
            default: put_char(8'h09);
         endcase
      end
   endtask

   // ':' LL AAAA TT data CC, with an optional flaw (a bad sum, or at a random digit).
   // Returns with trunc set if the text was cut short.
   task automatic put_record(input int len, input int addr, input logic [7:0] kind,
                             input int flaw, output bit trunc);
      logic [7:0] bytes [$];
      logic [7:0] s;
      int pos;
      bytes = {8'(len), 8'(addr >> 8), 8'(addr), kind};
      repeat (len) bytes.push_back(8'($urandom));
      s = 0;
      foreach (bytes[i]) s += bytes[i];
      bytes.push_back((flaw == FL_CSUM) ? 8'(-s + $urandom_range(1, 255)) : 8'(-s));
      pos = $urandom_range(0, 2 * bytes.size() - 1);
      trunc = 0;
      put_char(":");
      for (int i = 0; i < 2 * bytes.size(); i++) begin
         if (i == pos && flaw == FL_TRUNC) begin
            trunc = 1;
            return;
         end
         if (i == pos && flaw == FL_BADCHAR) put_char(junk_char());
         else if (i == pos && flaw == FL_SPACE) put_char(" ");
         else put_char(nib_char(i[0] ? bytes[i >> 1][3:0] : bytes[i >> 1][7:4]));
      end
   endtask

   // A whole load. Most are clean; the rest carry one or two kinds of defect.
   task automatic put_load();
      int sel, nrec, len, addr, flaw_at;
      logic [7:0] kind;
      bit trunc;
      sel = $urandom_range(0, 99);
      nrec = $urandom_range(1, 4);
      flaw_at = $urandom_range(0, nrec - 1);
      for (int r = 0; r < nrec; r++) begin
         put_space();
         len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
         addr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hffff)
                                            : $urandom_range(0, 127);
         if (sel < 60 || r != flaw_at) begin
            // clean records must stay inside the image
            if (addr + len > BYTE_LIMIT) addr = addr & 16'h3fff;
            put_record(len, addr, KIND_DATA, FL_NONE, trunc);
         end else if (sel < 66) begin
            put_record(len, addr, KIND_DATA, FL_CSUM, trunc);
         end else if (sel < 72) begin
            put_record(len, addr, KIND_DATA, FL_BADCHAR, trunc);
         end else if (sel < 76) begin
            put_record(len, addr, KIND_DATA, FL_SPACE, trunc);
         end else if (sel < 82) begin
            put_record(len, addr, KIND_DATA, FL_TRUNC, trunc);
            if (trunc) begin
               send(OP_END, 8'($urandom), 14'($urandom));
               return;
            end
         end else if (sel < 88) begin
            kind = 8'($urandom_range(2, 255));
            put_record(len, addr, kind, FL_NONE, trunc);
         end else begin
            // straddle or pass the top of the image
            len = $urandom_range(2, 16);
            addr = $urandom_range(0, 1) ? BYTE_LIMIT - $urandom_range(1, len - 1)
                                        : $urandom_range(BYTE_LIMIT, 16'hffff);
            put_record(len, addr, KIND_DATA, FL_NONE, trunc);
         end
      end
      put_space();
      if (!(sel >= 94 && sel < 97))
         put_record(0, $urandom_range(0, 16'hffff), KIND_EOF, FL_NONE, trunc);
      put_space();
      if (sel >= 97) put_char($urandom_range(0, 1) ? ":" : junk_char());
      send(OP_END, 8'($urandom), 14'($urandom));
   endtask

   initial begin
      bit trunc;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty text, extreme reads, unused op
      send(OP_END, 8'h00, 14'h0000);
      send(OP_READ, 8'hff, 14'h0000);
      send(OP_READ, 8'h00, 14'h3fff);
      send(OP_NONE, 8'hff, 14'h3fff);
      // full-length record ending on the last byte of the image
      put_record(REC_MAX, BYTE_LIMIT - REC_MAX, KIND_DATA, FL_NONE, trunc);
      put_record(0, 0, KIND_DATA, FL_NONE, trunc);
      put_record(0, 0, KIND_EOF, FL_NONE, trunc);
      send(OP_END, 8'h00, 14'h0000);
      send(OP_READ, 8'h00, 14'h3fff);
      send(OP_READ, 8'h00, 14'h3f81);
      // overflow by one byte, then an unsupported type
      put_record(2, BYTE_LIMIT - 1, KIND_DATA, FL_NONE, trunc);
      send(OP_END, 8'h00, 14'h0000);
      put_record(0, 0, 8'hff, FL_NONE, trunc);
      send(OP_END, 8'h00, 14'h0000);

      // random loads with reads of the committed image, and some unused ops, between them
      while (sent < 1900) begin
         put_load();
         repeat ($urandom_range(4, 30))
            send($urandom_range(0, 9) == 0 ? OP_NONE : OP_READ, 8'($urandom),
                 14'($urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom));
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* sim.f */
hdl/ihl_pkg.sv
hdl/ihl_front.sv
hdl/ihl_queue.sv
hdl/ihl_back.sv
hdl/intel_hex_image_loader.sv
tb/ihl_checker.sv
tb/intel_hex_image_loader_tb.sv
